// File: rtl/cac_pkg.sv
// Shared types and constants for the contiguous allocator with compaction.
// Used by the cell, controller, top level and checker; no dependencies.
`timescale 1ns / 1ps

package cac_pkg;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;
	localparam int LIMIT_W     = 9;
	localparam int SIZE_W      = 9;
	localparam int PID_W       = 8;
	localparam int STATUS_W    = 2;
	localparam int MOVED_W     = 8;
	localparam int USED_W      = 9;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	// Commands broadcast from the controller to every cell of the chain.
	typedef struct packed {
		logic rotate;
		logic compact;
		logic fill;
	} cell_ctl_t;

endpackage

// File: rtl/contiguous_alloc_compactor.sv
// Top level of the contiguous allocator with compaction: the controller and the
// chain of MEM_UNITS unit cells. Depends on cac_pkg, cac_cell and cac_ctrl.
`timescale 1ns / 1ps

// Each memory unit lives in a cell of a chain whose first cell feeds the
// controller. An allocate transaction goes from acceptance to the finish state,
// where the range check and the tagging of all new units happen in the same
// cycle. A release of a nonzero id first rotates the chain once through the
// controller to locate the run; if the run is found, every unit above the gap
// then steps down one place per cycle until the gap is closed. A release of id
// zero skips the search. One transaction is in work at a time; a result waits
// in the output register while the next transaction is accepted. The store is
// cleared by reset itself, so no clearing pass follows reset.
module contiguous_alloc_compactor #(
	parameter int MEM_UNITS = 256,
	parameter int ID_BITS   = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cac_pkg::LIMIT_W-1:0]       cfg_wdata,     // mem_limit
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [cac_pkg::IN_TDATA_W-1:0]    s_tdata,       // process_id, alloc_size
	input  logic                              s_tuser,       // func
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [cac_pkg::OUT_TDATA_W-1:0]   m_tdata        // status, units_moved, used_units
);

	localparam int FILL_W = $clog2(MEM_UNITS + 1);

	cac_pkg::cell_ctl_t  ctl;
	logic [FILL_W-1:0]   start;
	logic [FILL_W-1:0]   lo;
	logic [FILL_W-1:0]   hi;
	logic [ID_BITS-1:0]  id;
	logic [ID_BITS-1:0]  feed;
	logic [ID_BITS-1:0]  owner [MEM_UNITS];

	cac_ctrl #(
		.MEM_UNITS (MEM_UNITS),
		.ID_BITS   (ID_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.head      (owner[0]),
		.ctl       (ctl),
		.start     (start),
		.lo        (lo),
		.hi        (hi),
		.id        (id)
	);

	// The top cell wraps around to the head while rotating and takes a free
	// unit while compacting.
	assign feed = ctl.rotate ? owner[0] : '0;

	for (genvar i = 0; i < MEM_UNITS; i++) begin : g_cell
		logic [ID_BITS-1:0] nbr;
		if (i == MEM_UNITS - 1) begin : g_top
			assign nbr = feed;
		end else begin : g_mid
			assign nbr = owner[i+1];
		end
		cac_cell #(
			.ID_BITS (ID_BITS),
			.FILL_W  (FILL_W),
			.INDEX   (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.start  (start),
			.lo     (lo),
			.hi     (hi),
			.id     (id),
			.nbr    (nbr),
			.owner  (owner[i])
		);
	end

endmodule

// File: rtl/cac_cell.sv
// One memory unit of the chain: holds the owner id of its unit.
// Depends on cac_pkg for the command struct.
`timescale 1ns / 1ps

module cac_cell #(
	parameter int ID_BITS = 8,
	parameter int FILL_W  = 9,
	parameter int INDEX   = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cac_pkg::cell_ctl_t  ctl,
	input  logic [FILL_W-1:0]   start,
	input  logic [FILL_W-1:0]   lo,
	input  logic [FILL_W-1:0]   hi,
	input  logic [ID_BITS-1:0]  id,
	input  logic [ID_BITS-1:0]  nbr,
	output logic [ID_BITS-1:0]  owner
);

	localparam logic [FILL_W-1:0] MY_IDX = FILL_W'(INDEX);

	logic [ID_BITS-1:0] owner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q <= '0;
		end else if (ctl.rotate) begin
			owner_q <= nbr;
		end else if (ctl.compact && (MY_IDX >= start)) begin
			// Every unit at or above the gap steps down by one place.
			owner_q <= nbr;
		end else if (ctl.fill && (MY_IDX >= lo) && (MY_IDX < hi)) begin
			owner_q <= id;
		end
	end

	assign owner = owner_q;

endmodule

// File: rtl/cac_ctrl.sv
// Controller: stream handshakes, limit register, fill level, run search at the
// head of the cell chain and result formatting. Depends on cac_pkg.
`timescale 1ns / 1ps

module cac_ctrl #(
	parameter int MEM_UNITS = 256,
	parameter int ID_BITS   = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [cac_pkg::LIMIT_W-1:0]          cfg_wdata,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [cac_pkg::IN_TDATA_W-1:0]       s_tdata,
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [cac_pkg::OUT_TDATA_W-1:0]      m_tdata,
	input  logic [ID_BITS-1:0]                   head,
	output cac_pkg::cell_ctl_t                   ctl,
	output logic [$clog2(MEM_UNITS+1)-1:0]       start,
	output logic [$clog2(MEM_UNITS+1)-1:0]       lo,
	output logic [$clog2(MEM_UNITS+1)-1:0]       hi,
	output logic [ID_BITS-1:0]                   id
);

	localparam int FILL_W = $clog2(MEM_UNITS + 1);
	localparam int IDX_W  = $clog2(MEM_UNITS);
	localparam int SUM_W  = ((FILL_W > cac_pkg::SIZE_W) ? FILL_W : cac_pkg::SIZE_W) + 1;
	localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(MEM_UNITS - 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_SHIFT  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]                        state_q;
	logic [cac_pkg::LIMIT_W-1:0]       limit_q;
	logic [FILL_W-1:0]                 fill_q;
	logic                              m_valid_q;
	logic [cac_pkg::OUT_TDATA_W-1:0]   m_data_q;
	logic                              func_q;
	logic [ID_BITS-1:0]                id_q;
	logic [cac_pkg::SIZE_W-1:0]        size_q;
	logic [IDX_W-1:0]                  pos_q;
	logic                              found_q;
	logic                              in_run_q;
	logic [FILL_W-1:0]                 start_q;
	logic [FILL_W-1:0]                 len_q;
	logic [FILL_W-1:0]                 sh_q;

	logic [ID_BITS+cac_pkg::PID_W-1:0] pid_ext;
	logic [ID_BITS-1:0]                in_id;
	logic                              hit;
	logic                              begin_run;
	logic                              extend_run;
	logic                              found_nx;
	logic                              in_run_nx;
	logic [FILL_W-1:0]                 len_nx;
	logic                              out_free;
	logic                              done;
	logic [SUM_W-1:0]                  sum;
	logic [SUM_W-1:0]                  lim_ext;
	logic [SUM_W-1:0]                  eff_limit;
	logic [cac_pkg::STATUS_W-1:0]      status;
	logic [FILL_W-1:0]                 moved;
	logic [FILL_W-1:0]                 fill_nx;
	logic [FILL_W+cac_pkg::MOVED_W-1:0] moved_ext;
	logic [FILL_W+cac_pkg::USED_W-1:0]  used_ext;

	// Ids wider than the port field are zero-extended, narrower ones masked.
	assign pid_ext = {{ID_BITS{1'b0}}, s_tdata[cac_pkg::PID_W-1:0]};
	assign in_id   = pid_ext[ID_BITS-1:0];

	// Run search: the chain rotates once, showing unit k at the head while pos_q is k.
	assign hit        = (head == id_q);
	assign begin_run  = !found_q && hit;
	assign extend_run = in_run_q && hit;
	assign found_nx   = found_q || hit;
	assign in_run_nx  = begin_run || extend_run;
	assign len_nx     = (begin_run || extend_run) ? len_q + 1'b1 : len_q;

	assign out_free = !m_valid_q || m_tready;
	assign done     = (state_q == ST_FINISH) && out_free;

	assign sum       = SUM_W'(fill_q) + SUM_W'(size_q);
	assign lim_ext   = SUM_W'(limit_q);
	assign eff_limit = (lim_ext < SUM_W'(MEM_UNITS)) ? lim_ext : SUM_W'(MEM_UNITS);

	always_comb begin
		status  = cac_pkg::ST_OK;
		moved   = '0;
		fill_nx = fill_q;
		if (func_q == cac_pkg::FUNC_ALLOC) begin
			if (sum > eff_limit) begin
				status = cac_pkg::ST_NO_ROOM;
			end else if (size_q == '0) begin
				status = cac_pkg::ST_ZERO_SIZE;
			end else begin
				fill_nx = sum[FILL_W-1:0];
			end
		end else begin
			if (found_q) begin
				moved   = fill_q - start_q - len_q;
				fill_nx = fill_q - len_q;
			end else begin
				status = cac_pkg::ST_NOT_FOUND;
			end
		end
	end

	assign moved_ext = {{cac_pkg::MOVED_W{1'b0}}, moved};
	assign used_ext  = {{cac_pkg::USED_W{1'b0}}, fill_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			limit_q   <= cac_pkg::LIMIT_RESET;
			fill_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			// A new result may replace the one leaving in the same cycle.
			if (done) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser == cac_pkg::FUNC_RELEASE && in_id != '0) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_SCAN: begin
					if (pos_q == LAST_POS) begin
						state_q <= found_nx ? ST_SHIFT : ST_FINISH;
					end
				end
				ST_SHIFT: begin
					if (sh_q == FILL_W'(1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						fill_q  <= fill_nx;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request and search registers carry no reset; acceptance initializes them.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					func_q   <= s_tuser;
					id_q     <= in_id;
					size_q   <= s_tdata[cac_pkg::PID_W +: cac_pkg::SIZE_W];
					pos_q    <= '0;
					found_q  <= 1'b0;
					in_run_q <= 1'b0;
					start_q  <= '0;
					len_q    <= '0;
				end
			end
			ST_SCAN: begin
				pos_q    <= pos_q + 1'b1;
				found_q  <= found_nx;
				in_run_q <= in_run_nx;
				len_q    <= len_nx;
				sh_q     <= len_nx;
				if (begin_run) begin
					start_q <= FILL_W'(pos_q);
				end
			end
			ST_SHIFT: begin
				sh_q <= sh_q - 1'b1;
			end
			default: begin
			end
		endcase
		if (done) begin
			m_data_q <= {5'd0, used_ext[cac_pkg::USED_W-1:0],
				moved_ext[cac_pkg::MOVED_W-1:0], status};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	assign ctl.rotate  = (state_q == ST_SCAN);
	assign ctl.compact = (state_q == ST_SHIFT);
	assign ctl.fill    = done && (func_q == cac_pkg::FUNC_ALLOC) && (status == cac_pkg::ST_OK);

	assign start = start_q;
	assign lo    = fill_q;
	assign hi    = sum[FILL_W-1:0];
	assign id    = id_q;

endmodule

// File: rtl/cac_checker.sv
// Port-level checks for the contiguous allocator with compaction, and the bind
// that attaches them to the top level. Depends on cac_pkg.
`timescale 1ns / 1ps

module cac_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [cac_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	// Only one transaction is in work: the input side closes right after one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a transaction was in work");

	// A new result only appears once the transaction that caused it left idle.
	a_result_needs_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without a transaction in work");

	// Failed operations never report moved units.
	a_fail_moves_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != cac_pkg::ST_OK) |-> m_tdata[9:2] == 8'd0)
		else $error("units moved reported on a failed operation");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind contiguous_alloc_compactor cac_checker u_cac_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: bench/tb_contiguous_alloc_compactor.sv
// Self-checking bench for contiguous_alloc_compactor: allocate and release traffic
// with random idling on both streams, checked by an in-bench allocator model.
// Depends on cac_pkg and the contiguous_alloc_compactor RTL.
`timescale 1ns / 1ps

module tb_contiguous_alloc_compactor;
	import cac_pkg::*;

	localparam int UNITS          = 256;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [MOVED_W-1:0]  moved;
		logic [USED_W-1:0]   used;
	} alloc_result_t;

	// Tracks the unit store and the fill level, and queues the result that each
	// accepted request must produce.
	class alloc_scoreboard;
		logic [PID_W-1:0] owner [UNITS];
		int unsigned      fill;
		int unsigned      limit;
		alloc_result_t    pending_q [$];
		int               errors;

		function new();
			foreach (owner[k]) owner[k] = '0;
			fill   = 0;
			limit  = LIMIT_RESET;
			errors = 0;
		endfunction

		function void set_limit(logic [LIMIT_W-1:0] value);
			limit = value;
		endfunction

		function int unsigned eff_limit();
			return (limit < UNITS) ? limit : UNITS;
		endfunction

		function int outstanding();
			return pending_q.size();
		endfunction

		function void note_request(logic func, logic [PID_W-1:0] id, logic [SIZE_W-1:0] size);
			alloc_result_t r;
			int unsigned   start, stop, len;
			bit            found;
			r.status = ST_OK;
			r.moved  = '0;
			found    = 0;
			start    = 0;
			if (func == FUNC_ALLOC) begin
				if (fill + size > eff_limit()) begin
					r.status = ST_NO_ROOM;
				end else if (size == 0) begin
					r.status = ST_ZERO_SIZE;
				end else begin
					for (int k = 0; k < size; k++) owner[fill + k] = id;
					fill += size;
				end
			end else begin
				if (id != 0) begin
					for (int k = 0; k < fill; k++) begin
						if (owner[k] == id) begin
							start = k;
							found = 1;
							break;
						end
					end
				end
				if (!found) begin
					r.status = ST_NOT_FOUND;
				end else begin
					stop = start;
					while (stop < fill && owner[stop] == id) stop++;
					len     = stop - start;
					r.moved = MOVED_W'(fill - stop);
					for (int k = start; k < fill - len; k++) owner[k] = owner[k + len];
					for (int k = fill - len; k < fill; k++) owner[k] = '0;
					fill -= len;
				end
			end
			r.used = USED_W'(fill);
			pending_q.push_back(r);
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] data);
			alloc_result_t want, got;
			got.status = data[1:0];
			got.moved  = data[9:2];
			got.used   = data[18:10];
			if (pending_q.size() == 0) begin
				$error("result 0x%h arrived with no request outstanding", data);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.moved !== want.moved) begin
				$error("units_moved: expected %0d, got %0d", want.moved, got.moved);
				errors++;
			end
			if (got.used !== want.used) begin
				$error("used_units: expected %0d, got %0d", want.used, got.used);
				errors++;
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [LIMIT_W-1:0]     cfg_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	alloc_scoreboard sb;
	logic [PID_W-1:0] id_pool [6];
	bit               steady;
	int               rx_hold;
	int               idle_cycles;

	contiguous_alloc_compactor u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(negedge clk) begin
		if (steady) begin
			m_tready <= 1'b1;
		end else if (rx_hold > 0) begin
			rx_hold--;
		end else if ($urandom_range(0, 1)) begin
			m_tready <= 1'b1;
			rx_hold = $urandom_range(0, 7);
		end else begin
			m_tready <= 1'b0;
			rx_hold = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Sends one request; a request that follows with no gap keeps tvalid high.
	task automatic request(input logic func, input logic [PID_W-1:0] id,
			input logic [SIZE_W-1:0] size);
		int gap;
		@(negedge clk);
		s_tuser  <= func;
		s_tdata  <= {{(IN_TDATA_W - SIZE_W - PID_W){1'b0}}, size, id};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_request(func, id, size);
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Holds the sender off until every result has come back.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.outstanding() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_limit(value);
	endtask

	// Mostly allocations and releases over a small set of owners, so that runs
	// get found, split and compacted; the rest probes the rejection paths.
	task automatic random_request();
		int               roll;
		logic [PID_W-1:0] id;
		logic [SIZE_W-1:0] size;
		roll = $urandom_range(0, 99);
		id   = id_pool[$urandom_range(0, 5)];
		if (roll < 50 && sb.fill * 4 > sb.eff_limit() * 3) roll = 60;
		if (roll < 50) begin
			roll = $urandom_range(0, 99);
			if (roll < 80) size = SIZE_W'($urandom_range(1, 8));
			else if (roll < 95) size = SIZE_W'($urandom_range(9, 40));
			else size = SIZE_W'($urandom_range(41, UNITS));
			request(FUNC_ALLOC, id, size);
		end else if (roll < 85) begin
			request(FUNC_RELEASE, id, SIZE_W'($urandom_range(0, 511)));
		end else if (roll < 90) begin
			request(FUNC_RELEASE, PID_W'($urandom_range(0, 255)),
				SIZE_W'($urandom_range(0, 511)));
		end else if (roll < 94) begin
			request(FUNC_ALLOC, PID_W'($urandom_range(1, 255)), '0);
		end else if (roll == 94 && $urandom_range(0, 3) == 0) begin
			// Units tagged zero can never be released, so this stays rare.
			request(FUNC_ALLOC, '0, 9'd1);
		end else begin
			request(FUNC_ALLOC, PID_W'($urandom_range(1, 255)),
				SIZE_W'($urandom_range(0, UNITS)));
		end
	endtask

	initial begin
		logic [LIMIT_W-1:0] phase_limit [6];
		sb          = new();
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = FUNC_ALLOC;
		m_tready    = 1'b0;
		steady      = 0;
		rx_hold     = 0;
		idle_cycles = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		request(FUNC_RELEASE, 8'd5, '0);
		request(FUNC_ALLOC, 8'd1, '0);
		request(FUNC_ALLOC, 8'hFF, 9'd256);
		request(FUNC_ALLOC, 8'd1, 9'd1);
		request(FUNC_ALLOC, 8'd1, '0);
		request(FUNC_RELEASE, 8'hFF, 9'h1FF);
		request(FUNC_ALLOC, 8'd1, 9'd1);
		request(FUNC_ALLOC, 8'd2, 9'd255);
		request(FUNC_RELEASE, 8'd1, '0);
		request(FUNC_RELEASE, 8'd2, '0);
		request(FUNC_ALLOC, 8'hAA, 9'd5);
		request(FUNC_ALLOC, 8'h55, 9'd2);
		request(FUNC_ALLOC, 8'hAA, 9'd4);
		request(FUNC_RELEASE, 8'd0, '0);
		request(FUNC_RELEASE, 8'hAA, '0);
		request(FUNC_RELEASE, 8'hAA, '0);
		request(FUNC_RELEASE, 8'h55, '0);
		drain();
		write_limit(9'd0);
		request(FUNC_ALLOC, 8'd7, 9'd1);
		request(FUNC_ALLOC, 8'd7, '0);
		drain();
		write_limit(9'd1);
		request(FUNC_ALLOC, 8'd7, 9'd1);
		request(FUNC_ALLOC, 8'd8, 9'd1);
		request(FUNC_RELEASE, 8'd7, '0);
		drain();
		write_limit(9'd511);
		request(FUNC_ALLOC, 8'd9, 9'd256);
		request(FUNC_ALLOC, 8'd9, 9'd1);
		request(FUNC_RELEASE, 8'd9, '0);
		request(FUNC_ALLOC, 8'd0, 9'd1);
		request(FUNC_RELEASE, 8'd0, '0);

		phase_limit = '{9'd256, 9'd511, 9'd40, 9'd1, 9'($urandom_range(2, 255)), 9'd256};
		for (int p = 0; p < 6; p++) begin
			drain();
			write_limit(phase_limit[p]);
			foreach (id_pool[k]) id_pool[k] = PID_W'($urandom_range(1, 255));
			steady = (p == 2);
			for (int n = 0; n < 190; n++) begin
				random_request();
				if ($urandom_range(0, 99) == 0) drain();
			end
		end
		steady = 0;

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/cac_pkg.sv
rtl/cac_cell.sv
rtl/cac_ctrl.sv
rtl/contiguous_alloc_compactor.sv
rtl/cac_checker.sv
bench/tb_contiguous_alloc_compactor.sv
